// ----- rtl/core/tia_pkg.sv -----
package tia_pkg;

    localparam int unsigned IdW     = 8;
    localparam int unsigned TypeW   = 2;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgW    = 3;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 3'd0,
        ST_UNISSUED  = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // outcome of one item, passed from the tracker to the result stage
    typedef struct packed {
        status_t status;
        logic    pop;
        logic    push;
        logic    fresh;
    } decision_t;

endpackage

// ----- rtl/core/tia_stack_ram.sv -----
module tia_stack_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic                    re,
    input  logic [AW-1:0]           addr,
    input  logic [tia_pkg::IdW-1:0] wdata,
    output logic [tia_pkg::IdW-1:0] rdata
);

    logic [tia_pkg::IdW-1:0] mem [DEPTH];
    logic [tia_pkg::IdW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // hold the read data until the next pop is taken
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tia_tracker.sv -----
module tia_tracker #(
    parameter int unsigned NUM_TYPES    = 4,
    parameter int unsigned IDS_PER_TYPE = 256,
    parameter int unsigned AW           = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic                        cmd,
    input  logic [tia_pkg::TypeW-1:0]   res_type,
    input  logic [tia_pkg::IdW-1:0]     id_value,
    input  logic [tia_pkg::CfgW-1:0]    types_in_use,
    output tia_pkg::decision_t          dec,
    output logic [AW-1:0]               addr,
    output logic [tia_pkg::IdW-1:0]     fresh_id
);

    localparam int unsigned CW = $clog2(IDS_PER_TYPE + 1);
    localparam int unsigned LW = $clog2(IDS_PER_TYPE);
    localparam int unsigned TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int unsigned XW = (CW > tia_pkg::IdW) ? CW : tia_pkg::IdW;

    logic [CW-1:0] fresh_reg [NUM_TYPES];
    logic [CW-1:0] level_reg [NUM_TYPES];

    logic [TW-1:0] tidx;
    logic [CW-1:0] fresh_cur;
    logic [CW-1:0] level_cur;
    logic [LW-1:0] slot;
    logic          bad;

    assign tidx      = TW'(res_type);
    assign fresh_cur = fresh_reg[tidx];
    assign level_cur = level_reg[tidx];
    assign bad       = ({1'b0, res_type} >= types_in_use) || (32'(res_type) >= NUM_TYPES);

    always_comb begin
        dec.status = tia_pkg::ST_OK;
        dec.pop    = 1'b0;
        dec.push   = 1'b0;
        dec.fresh  = 1'b0;
        slot       = LW'(level_cur);
        priority if (bad) begin
            dec.status = tia_pkg::ST_BAD_TYPE;
        end else if (cmd == tia_pkg::CMD_ALLOC) begin
            priority if (level_cur != '0) begin
                dec.pop = 1'b1;
                slot    = LW'(level_cur - CW'(1));
            end else if (32'(fresh_cur) < IDS_PER_TYPE) begin
                dec.fresh = 1'b1;
            end else begin
                dec.status = tia_pkg::ST_EXHAUSTED;
            end
        end else begin
            priority if (XW'(id_value) >= XW'(fresh_cur)) begin
                dec.status = tia_pkg::ST_UNISSUED;
            end else if (32'(level_cur) >= IDS_PER_TYPE) begin
                dec.status = tia_pkg::ST_FULL;
            end else begin
                dec.push = 1'b1;
            end
        end
    end

    assign addr     = AW'(tidx) * AW'(IDS_PER_TYPE) + AW'(slot);
    assign fresh_id = tia_pkg::IdW'(XW'(fresh_cur));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                fresh_reg[i] <= '0;
                level_reg[i] <= '0;
            end
        end else if (take) begin
            if (dec.fresh) begin
                fresh_reg[tidx] <= fresh_cur + CW'(1);
            end
            if (dec.pop) begin
                level_reg[tidx] <= level_cur - CW'(1);
            end else if (dec.push) begin
                level_reg[tidx] <= level_cur + CW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/typed_id_allocator_unit.sv -----
// Per-type identifier allocator with a LIFO free stack for each type.
// Input items arrive on the s_ stream: s_tuser carries the command
// (allocate or free) and the resource type, s_tdata the identifier
// being returned on a free. Each item gives exactly one result on the
// m_ stream: the granted identifier and a status code.
// An item is taken every cycle while the result register is empty or being
// drained; the result is registered and appears in the cycle after the item
// is taken. The per-type counters and stack levels update at the accept edge
// and the stack memory is written or read at that same edge, so a following
// item always sees the effect of the previous one at full rate. When m_tready
// is low the result is held and s_tready drops until it is taken. Reset clears
// the counters, stack levels and the result valid flag and sets types_in_use
// to 3; stack contents are not cleared. APB writes at addresses 0 to 3 set
// types_in_use; write it only while idle (the block does not enforce this).
module typed_id_allocator_unit #(
    parameter int unsigned NUM_TYPES    = 4,
    parameter int unsigned IDS_PER_TYPE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] id_value
    input  logic [2:0]  s_tuser,   // [0] cmd, [2:1] res_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] granted_id, [10:8] status, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DEPTH = NUM_TYPES * IDS_PER_TYPE;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [tia_pkg::CfgW-1:0]  types_in_use_reg;
    logic                      out_valid_reg;
    logic                      out_pop_reg;
    logic [tia_pkg::IdW-1:0]   out_grant_reg;
    tia_pkg::status_t          out_status_reg;

    tia_pkg::decision_t        dec;
    logic [AW-1:0]             addr;
    logic [tia_pkg::IdW-1:0]   fresh_id;
    logic [tia_pkg::IdW-1:0]   pop_data;
    logic                      take;
    logic [tia_pkg::IdW-1:0]   granted;

    assign pready   = 1'b1;
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            types_in_use_reg <= tia_pkg::CfgW'(3);
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            types_in_use_reg <= pwdata[tia_pkg::CfgW-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(types_in_use_reg);

    tia_tracker #(
        .NUM_TYPES    (NUM_TYPES),
        .IDS_PER_TYPE (IDS_PER_TYPE),
        .AW           (AW)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .cmd          (s_tuser[0]),
        .res_type     (s_tuser[2:1]),
        .id_value     (s_tdata),
        .types_in_use (types_in_use_reg),
        .dec          (dec),
        .addr         (addr),
        .fresh_id     (fresh_id)
    );

    tia_stack_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (take && dec.push),
        .re    (take && dec.pop),
        .addr  (addr),
        .wdata (s_tdata),
        .rdata (pop_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_pop_reg    <= dec.pop;
            out_grant_reg  <= dec.fresh ? fresh_id : '0;
            out_status_reg <= dec.status;
        end
    end

    // a popped identifier comes straight from the stack read register
    assign granted  = out_pop_reg ? pop_data : out_grant_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_status_reg, granted};

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned N_TYPES       = 4;
    localparam int unsigned IDS_EACH      = 256;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          HOLD_CYCLES   = 60;
    localparam int          DRAIN_PAD     = 4;
    localparam int          PHASE_ITEMS   = 40;
    localparam logic [2:0]  ADDR_TYPES    = 3'd0;
    localparam logic [2:0]  ADDR_NO_REG   = 3'd4;

    typedef struct {
        logic [tia_pkg::IdW-1:0] id;
        tia_pkg::status_t        status;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [2:0]  s_tuser = '0;   // [0] cmd, [2:1] res_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [7:0] granted_id, [10:8] status, rest zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    typed_id_allocator_unit #(
        .NUM_TYPES    (N_TYPES),
        .IDS_PER_TYPE (IDS_EACH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // allocator state as the block should hold it
    int unsigned             types_cfg = 3;
    int unsigned             fresh_next [N_TYPES];
    int unsigned             stack_depth [N_TYPES];
    logic [tia_pkg::IdW-1:0] stack_ids [N_TYPES][IDS_EACH];

    grant_t pending_grants [$];
    int     error_count = 0;
    bit     tx_gaps_on = 1'b1;
    bit     rx_stalls_on = 1'b1;
    int     rx_hold_left = 0;
    int     quiet_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int unsigned live_types();
        return (types_cfg > N_TYPES) ? N_TYPES : types_cfg;
    endfunction

    function automatic grant_t predict_grant(input tia_pkg::cmd_t c, input logic [1:0] t,
                                             input logic [7:0] id);
        grant_t g;
        g.id = '0;
        g.status = tia_pkg::ST_OK;
        if (t >= live_types()) begin
            g.status = tia_pkg::ST_BAD_TYPE;
        end else if (c == tia_pkg::CMD_ALLOC) begin
            if (stack_depth[t] > 0) begin
                stack_depth[t]--;
                g.id = stack_ids[t][stack_depth[t]];
            end else if (fresh_next[t] < IDS_EACH) begin
                g.id = fresh_next[t][tia_pkg::IdW-1:0];
                fresh_next[t]++;
            end else begin
                g.status = tia_pkg::ST_EXHAUSTED;
            end
        end else begin
            if (id >= fresh_next[t]) begin
                g.status = tia_pkg::ST_UNISSUED;
            end else if (stack_depth[t] >= IDS_EACH) begin
                g.status = tia_pkg::ST_FULL;
            end else begin
                stack_ids[t][stack_depth[t]] = id;
                stack_depth[t]++;
            end
        end
        return g;
    endfunction

    task automatic send_item(input tia_pkg::cmd_t c, input logic [1:0] t,
                             input logic [7:0] id);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= {t, c};
        do @(posedge aclk); while (!s_tready);
        pending_grants.insert(pending_grants.size(), predict_grant(c, t, id));
    endtask

    // drop valid and wait until every result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr && addr == ADDR_TYPES) begin
            types_cfg = wdata & 32'h7;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a register, then read back the type count
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, addr, value, rd);
        apb_access(1'b0, ADDR_TYPES, '0, rd);
        if (rd !== types_cfg) begin
            report_mismatch("types_in_use readback", rd, types_cfg);
        end
    endtask

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata, 0);
            end else begin
                want = pending_grants.pop_front();
                if (m_tdata[7:0] !== want.id) begin
                    report_mismatch("granted_id", m_tdata[7:0], want.id);
                end
                if (m_tdata[10:8] !== want.status) begin
                    report_mismatch("status", m_tdata[10:8], want.status);
                end
                if (m_tdata[15:11] !== '0) begin
                    report_mismatch("padding bits", m_tdata[15:11], 0);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_alloc_free_basics();
        send_item(tia_pkg::CMD_ALLOC, 2'd0, 8'hFF);
        send_item(tia_pkg::CMD_ALLOC, 2'd0, 8'h00);
        send_item(tia_pkg::CMD_FREE,  2'd0, 8'd0);
        send_item(tia_pkg::CMD_ALLOC, 2'd0, 8'hA5);   // pops 0 back
        send_item(tia_pkg::CMD_FREE,  2'd0, 8'd200);  // never issued
        send_item(tia_pkg::CMD_FREE,  2'd0, 8'd255);
        send_item(tia_pkg::CMD_FREE,  2'd0, 8'd2);    // just past the counter
        send_item(tia_pkg::CMD_ALLOC, 2'd3, 8'h00);   // beyond types in use
        send_item(tia_pkg::CMD_FREE,  2'd3, 8'd0);
        send_item(tia_pkg::CMD_ALLOC, 2'd1, 8'h5A);
        send_item(tia_pkg::CMD_ALLOC, 2'd2, 8'h00);
        send_item(tia_pkg::CMD_FREE,  2'd1, 8'd0);
        send_item(tia_pkg::CMD_FREE,  2'd1, 8'd0);    // duplicate free goes on the stack twice
        send_item(tia_pkg::CMD_ALLOC, 2'd1, 8'h00);
        send_item(tia_pkg::CMD_ALLOC, 2'd1, 8'h00);
        send_item(tia_pkg::CMD_ALLOC, 2'd1, 8'h00);
        drain_results();
    endtask

    task automatic test_type_count_extremes();
        write_reg(ADDR_TYPES, 32'd0);        // every type rejected
        send_item(tia_pkg::CMD_ALLOC, 2'd0, 8'h00);
        send_item(tia_pkg::CMD_FREE,  2'd0, 8'd0);
        drain_results();
        write_reg(ADDR_TYPES, 32'hFFFF_FFFC); // masks to 4
        send_item(tia_pkg::CMD_ALLOC, 2'd3, 8'h00);
        drain_results();
        write_reg(ADDR_TYPES, 32'd7);        // clamps to all types
        send_item(tia_pkg::CMD_ALLOC, 2'd3, 8'h00);
        send_item(tia_pkg::CMD_FREE,  2'd3, 8'd1);
        drain_results();
        write_reg(ADDR_NO_REG, 32'd1);       // no register there: ignored
        send_item(tia_pkg::CMD_ALLOC, 2'd3, 8'h00);
        drain_results();
        write_reg(ADDR_TYPES, 32'd1);
        send_item(tia_pkg::CMD_ALLOC, 2'd1, 8'h00);
        send_item(tia_pkg::CMD_ALLOC, 2'd0, 8'h00);
        drain_results();
    endtask

    task automatic test_exhaust_and_overfill();
        int k;
        write_reg(ADDR_TYPES, 32'd4);
        for (k = 0; k < IDS_EACH + 2; k++) begin
            send_item(tia_pkg::CMD_ALLOC, 2'd2, 8'($urandom_range(0, 255)));
        end
        for (k = 0; k < IDS_EACH; k++) begin
            send_item(tia_pkg::CMD_FREE, 2'd2, 8'(k));
        end
        send_item(tia_pkg::CMD_FREE, 2'd2, 8'd7);     // stack already holds every id
        send_item(tia_pkg::CMD_FREE, 2'd2, 8'd255);
        for (k = 0; k < 4; k++) begin
            send_item(tia_pkg::CMD_ALLOC, 2'd2, 8'h00);
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        int k;
        tx_gaps_on = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        for (k = 0; k < 20; k++) begin
            send_item(k[0] ? tia_pkg::CMD_FREE : tia_pkg::CMD_ALLOC,
                      2'($urandom_range(0, 3)), 8'($urandom_range(0, 15)));
        end
        tx_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned   phase_cfg [5] = '{3, 4, 2, 1, 4};
        int            p;
        int            k;
        int unsigned   r;
        int unsigned   act;
        logic [1:0]    t;
        logic [7:0]    id;
        tia_pkg::cmd_t c;
        for (p = 0; p < 5; p++) begin
            write_reg(ADDR_TYPES, phase_cfg[p]);
            if (p == 4) begin
                tx_gaps_on = 1'b0;
                rx_stalls_on = 1'b0;
            end
            act = live_types();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r  = $urandom_range(0, 99);
                t  = (r % 10 == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, act - 1));
                id = 8'($urandom_range(0, 255));
                if (r < 45) begin
                    c = tia_pkg::CMD_ALLOC;
                end else if (r < 85) begin
                    c = tia_pkg::CMD_FREE;
                    if (fresh_next[t] > 0) begin
                        id = 8'($urandom_range(0, fresh_next[t] - 1));
                    end
                end else begin
                    c = tia_pkg::cmd_t'($urandom_range(0, 1));
                end
                send_item(c, t, id);
            end
            drain_results();
        end
    endtask

    initial begin
        foreach (fresh_next[i]) begin
            fresh_next[i] = 0;
            stack_depth[i] = 0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_alloc_free_basics();
        test_type_count_extremes();
        test_exhaust_and_overfill();
        test_backpressure();
        test_random_traffic();

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tia_pkg.sv
rtl/core/tia_stack_ram.sv
rtl/core/tia_tracker.sv
rtl/core/typed_id_allocator_unit.sv
tb/sv/testbench.sv
